// File: hw/rtl/pae_pkg.sv
// Package for the positional array editor: sizes, codes, item structs and the
// command that the control logic broadcasts to the row of storage cells.
// No dependencies.
package pae_pkg;

    localparam int DEPTH  = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Width used for position and count compares; wide enough for the 6-bit
    // position field, for DEPTH itself and for one more.
    localparam int CMP_W  = ((CNT_W > 6) ? CNT_W : 6) + 1;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_APPEND = 2'd2,
        REQ_ROTATE = 2'd3
    } t_req_op;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_APPEND,
        CELL_ROTATE
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [5:0]               position;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic                     elem_valid;
        logic [4:0]               elem_index;
        logic signed [DATA_W-1:0] elem_value;
        logic [5:0]               count;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        t_cell_op                 op;
        logic [CMP_W-1:0]         pos0;
        logic [CMP_W-1:0]         cnt;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

// File: hw/rtl/pae_cell.sv
// One storage cell of the positional array editor chain.
// Depends on pae_pkg for the command struct and the sizes.
module pae_cell (
    input  logic                              i_clk,
    input  pae_pkg::t_cell_cmd                i_cmd,
    input  logic [pae_pkg::IDX_W-1:0]         i_index,
    input  logic signed [pae_pkg::DATA_W-1:0] i_left,
    input  logic signed [pae_pkg::DATA_W-1:0] i_right,
    input  logic signed [pae_pkg::DATA_W-1:0] i_first,
    output logic signed [pae_pkg::DATA_W-1:0] o_data
);
    import pae_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [CMP_W-1:0]         idx;
    logic [CMP_W-1:0]         idx_p1;

    assign idx    = CMP_W'(i_index);
    assign idx_p1 = idx + CMP_W'(1);

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_INSERT: begin
                // Cells above the slot take their lower neighbor.
                if (idx > i_cmd.pos0 && idx <= i_cmd.cnt) begin
                    n_data = i_left;
                end else if (idx == i_cmd.pos0) begin
                    n_data = i_cmd.value;
                end
            end
            CELL_DELETE: begin
                if (idx >= i_cmd.pos0 && idx_p1 < i_cmd.cnt) begin
                    n_data = i_right;
                end
            end
            CELL_APPEND: begin
                if (idx == i_cmd.cnt) begin
                    n_data = i_cmd.value;
                end
            end
            CELL_ROTATE: begin
                // The occupied part of the row turns left by one place.
                if (idx_p1 < i_cmd.cnt) begin
                    n_data = i_right;
                end else if (idx_p1 == i_cmd.cnt) begin
                    n_data = i_first;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: hw/rtl/positional_array_editor.sv
// Top level of the positional array editor: request decode, control and the
// output register around a row of pae_cell storage cells.
// Depends on pae_pkg and pae_cell.
//
// The list lives in a row of DEPTH cells, one element each; an insert, delete,
// append or rotate edits the whole row in the cycle the request item is
// accepted. The list is then read out from cell 0 while the occupied cells turn
// left by one place each cycle that the output register is free, which returns
// them to their order after the last element. A request gives one result item
// per element, or a single error or empty item, and the input stalls until its
// last result has been loaded into the output register. The output register
// lets the next request be accepted while that last result still waits to be
// taken.
module positional_array_editor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pae_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pae_pkg::t_out_item o_out_item
);
    import pae_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [IDX_W-1:0]   r_k;
    logic [IDX_W-1:0]   n_k;
    t_status            r_status;
    t_status            n_status;
    logic               r_err;
    logic               n_err;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic               load_out;
    logic               out_free;
    logic               emit_last;
    t_cell_cmd          cmd;
    t_status            req_status;
    logic [CNT_W-1:0]   req_count;
    t_cell_op           req_op;
    logic [CMP_W-1:0]   pos_w;
    logic [CMP_W-1:0]   cnt_w;
    logic [CMP_W-1:0]   k_w;
    logic [CMP_W-1:0]   full_w;

    logic signed [DATA_W-1:0] w_data [DEPTH];

    assign pos_w     = CMP_W'(i_in_item.position);
    assign cnt_w     = CMP_W'(r_count);
    assign k_w       = CMP_W'(r_k);
    assign full_w    = CMP_W'(DEPTH);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_last = r_err || (k_w + CMP_W'(1) == cnt_w);

    // Request decode: full and empty are checked before the position.
    always_comb begin
        req_status = STAT_OK;
        req_count  = r_count;
        req_op     = CELL_HOLD;
        unique case (t_req_op'(i_in_item.req_type))
            REQ_INSERT: begin
                if (cnt_w == full_w) begin
                    req_status = STAT_FULL;
                end else if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
                    req_status = STAT_BADPOS;
                end else begin
                    req_op    = CELL_INSERT;
                    req_count = r_count + CNT_W'(1);
                end
            end
            REQ_DELETE: begin
                if (cnt_w == '0) begin
                    req_status = STAT_EMPTY;
                end else if (pos_w == '0 || pos_w > cnt_w) begin
                    req_status = STAT_BADPOS;
                end else begin
                    req_op    = CELL_DELETE;
                    req_count = r_count - CNT_W'(1);
                end
            end
            REQ_APPEND: begin
                if (cnt_w == full_w) begin
                    req_status = STAT_FULL;
                end else begin
                    req_op    = CELL_APPEND;
                    req_count = r_count + CNT_W'(1);
                end
            end
            REQ_ROTATE: begin
                if (cnt_w == '0) begin
                    req_status = STAT_EMPTY;
                end else begin
                    req_op = CELL_ROTATE;
                end
            end
            default: begin
                req_status = STAT_OK;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb begin
        o_in_stall = 1'b1;
        n_count    = r_count;
        n_k        = r_k;
        n_status   = r_status;
        n_err      = r_err;
        load_out   = 1'b0;
        cmd.op     = CELL_HOLD;
        cmd.pos0   = pos_w - CMP_W'(1);
        cmd.cnt    = cnt_w;
        cmd.value  = i_in_item.value;

        n_out.status     = r_status;
        n_out.elem_valid = !r_err;
        n_out.elem_index = r_err ? 5'd0 : k_w[4:0];
        n_out.elem_value = r_err ? '0 : w_data[0];
        n_out.count      = cnt_w[5:0];
        n_out.last       = emit_last;

        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    cmd.op   = req_op;
                    n_count  = req_count;
                    n_status = req_status;
                    n_err    = (req_status != STAT_OK) || (req_count == '0);
                    n_k      = '0;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (!r_err) begin
                        cmd.op = CELL_ROTATE;
                        n_k    = r_k + IDX_W'(1);
                    end
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_status    <= STAT_OK;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_k      <= n_k;
            r_status <= n_status;
            r_err    <= n_err;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic signed [DATA_W-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid_left
            assign left_data = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_mid_right
            assign right_data = w_data[g+1];
        end

        pae_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_index (IDX_W'(g)),
            .i_left  (left_data),
            .i_right (right_data),
            .i_first (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for positional_array_editor: drives insert, delete, append
// and rotate requests with random idling on both channels and checks every listed element.
// Depends on pae_pkg and the positional_array_editor RTL.
module tb_top;
    import pae_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 460;
    localparam int CALM_ITEMS = 60;

    // Tracks the list as the block should hold it and queues the elements each
    // accepted request should produce.
    class edit_tracker;
        logic signed [DATA_W-1:0] cells [DEPTH];
        int size;
        int errors;
        t_out_item expected_items [$];

        function new();
            size = 0;
            errors = 0;
        endfunction

        function void apply_request(t_in_item req);
            t_status st;
            int p;
            t_out_item res;
            logic signed [DATA_W-1:0] first;
            st = STAT_OK;
            p = int'(req.position);
            case (t_req_op'(req.req_type))
                REQ_INSERT: begin
                    if (size >= DEPTH) begin
                        st = STAT_FULL;
                    end else if (p < 1 || p > size + 1) begin
                        st = STAT_BADPOS;
                    end else begin
                        for (int i = size; i > p - 1; i--) cells[i] = cells[i-1];
                        cells[p-1] = req.value;
                        size++;
                    end
                end
                REQ_DELETE: begin
                    if (size == 0) begin
                        st = STAT_EMPTY;
                    end else if (p < 1 || p > size) begin
                        st = STAT_BADPOS;
                    end else begin
                        for (int i = p - 1; i + 1 < size; i++) cells[i] = cells[i+1];
                        size--;
                    end
                end
                REQ_APPEND: begin
                    if (size >= DEPTH) begin
                        st = STAT_FULL;
                    end else begin
                        cells[size] = req.value;
                        size++;
                    end
                end
                default: begin
                    if (size == 0) begin
                        st = STAT_EMPTY;
                    end else begin
                        first = cells[0];
                        for (int i = 0; i + 1 < size; i++) cells[i] = cells[i+1];
                        cells[size-1] = first;
                    end
                end
            endcase

            if (st != STAT_OK || size == 0) begin
                res = '0;
                res.status = st;
                res.count = 6'(size);
                res.last = 1'b1;
                expected_items.push_back(res);
            end else begin
                for (int k = 0; k < size; k++) begin
                    res.status = STAT_OK;
                    res.elem_valid = 1'b1;
                    res.elem_index = 5'(k);
                    res.elem_value = cells[k];
                    res.count = 6'(size);
                    res.last = (k == size - 1);
                    expected_items.push_back(res);
                end
            end
        endfunction

        function void compare_field(string name, longint exp_val, longint act_val);
            if (exp_val != act_val) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_item;
            if (expected_items.size() == 0) begin
                $error("item arrived with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_item = expected_items.pop_front();
            compare_field("status", longint'(exp_item.status), longint'(got.status));
            compare_field("elem_valid", longint'(exp_item.elem_valid),
                          longint'(got.elem_valid));
            compare_field("elem_index", longint'(exp_item.elem_index),
                          longint'(got.elem_index));
            compare_field("elem_value", longint'(exp_item.elem_value),
                          longint'(got.elem_value));
            compare_field("count", longint'(exp_item.count), longint'(got.count));
            compare_field("last", longint'(exp_item.last), longint'(got.last));
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      o_in_stall;
    t_in_item  in_item;
    logic      o_out_valid;
    logic      out_stall;
    t_out_item o_out_item;

    edit_tracker tracker;
    bit idling;
    int stall_left;
    int cycles;

    positional_array_editor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        idling = 1'b1;
        stall_left = 0;
        cycles = 0;
        tracker = new();
    end

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver side: stall in short random bursts while idling is enabled.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (idling && $urandom_range(0, 4) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) tracker.apply_request(in_item);
            if (o_out_valid && !out_stall) tracker.check_result(o_out_item);
        end
    end

    // Entered just after a rising edge; returns at the edge that accepts the item.
    task automatic send_request(t_in_item req);
        int gap;
        gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item <= req;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_op(t_req_op op, int pos, logic [DATA_W-1:0] val);
        t_in_item req;
        req.req_type = op;
        req.position = 6'(pos);
        req.value = val;
        send_request(req);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed requests steered toward a full or an empty list, with
    // some noise that lands on bad positions and ignored position bits.
    function automatic t_in_item make_request(bit grow, int n);
        t_in_item req;
        int roll;
        req.value = pick_value();
        req.position = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 12) begin
            req.req_type = 2'($urandom_range(0, 3));
            return req;
        end
        roll = $urandom_range(0, 99);
        if (grow) begin
            req.req_type = (roll < 45) ? REQ_APPEND : (roll < 85) ? REQ_INSERT :
                           (roll < 93) ? REQ_DELETE : REQ_ROTATE;
        end else begin
            req.req_type = (roll < 15) ? REQ_APPEND : (roll < 30) ? REQ_INSERT :
                           (roll < 80) ? REQ_DELETE : REQ_ROTATE;
        end
        if (req.req_type == REQ_INSERT) begin
            req.position = 6'($urandom_range(1, n + 1));
        end else if (req.req_type == REQ_DELETE) begin
            req.position = 6'((n == 0) ? 1 : $urandom_range(1, n));
        end
        return req;
    endfunction

    initial begin
        bit grow;
        #1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Errors on an empty list, then edits at both ends and in the middle.
        send_op(REQ_ROTATE, 0, 32'h0);
        send_op(REQ_DELETE, 1, 32'h0);
        send_op(REQ_INSERT, 0, 32'h1234_5678);
        send_op(REQ_INSERT, 2, 32'h1234_5678);
        send_op(REQ_INSERT, 1, 32'h7fff_ffff);
        send_op(REQ_APPEND, 63, 32'h8000_0000);
        send_op(REQ_INSERT, 3, 32'hffff_ffff);
        send_op(REQ_INSERT, 1, 32'h0000_0000);
        send_op(REQ_INSERT, 63, 32'h0bad_0bad);
        send_op(REQ_DELETE, 0, 32'h0);
        send_op(REQ_DELETE, 5, 32'h0);
        send_op(REQ_ROTATE, 42, 32'hffff_ffff);
        send_op(REQ_DELETE, 4, 32'h0);
        send_op(REQ_DELETE, 1, 32'h0);
        send_op(REQ_DELETE, 2, 32'h0);
        // A single element rotates onto itself; deleting it empties the list.
        send_op(REQ_ROTATE, 1, 32'h0);
        send_op(REQ_DELETE, 1, 32'h0);
        send_op(REQ_APPEND, 32, 32'h5555_5555);
        send_op(REQ_APPEND, 0, 32'haaaa_aaaa);
        send_op(REQ_INSERT, 2, $urandom);

        grow = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - CALM_ITEMS) idling = 1'b0;
            if (grow && tracker.size == DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
            if (!grow && tracker.size == 0 && $urandom_range(0, 2) == 0) grow = 1'b1;
            send_request(make_request(grow, tracker.size));
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        while (tracker.expected_items.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
